// ===== hw/rtl/dpsk_sync_costas_framer_defines.svh =====
// Assertion macros for the DBPSK sync/Costas/framer block.
// Used by modules that check their own control logic; needs clk and arst_n in scope.
`ifndef DPSK_SYNC_COSTAS_FRAMER_DEFINES_SVH
`define DPSK_SYNC_COSTAS_FRAMER_DEFINES_SVH

// same-cycle implication
`define DSCF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define DSCF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== hw/rtl/dscf_pkg.sv =====
// Shared types and constants of the DBPSK sync/Costas/framer block.
// No dependencies.
package dscf_pkg;

	localparam int WINDOW_LEN_DEF  = 20;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int WFRAC  = 21;
	localparam int WBITS  = 24;
	localparam int STEP_W = 16;
	localparam int PAT_W  = 32;
	localparam int FB_W   = 8;
	localparam int DL_W   = 7;
	localparam int CFG_W  = 32;
	localparam int CIDX_W = 3;
	localparam int BYTE_W = 8;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 25;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [CIDX_W-1:0] REG_STEP    = 3'd0;
	localparam logic [CIDX_W-1:0] REG_PATTERN = 3'd1;
	localparam logic [CIDX_W-1:0] REG_FBYTES  = 3'd2;
	localparam logic [CIDX_W-1:0] REG_DLIMIT  = 3'd3;

	localparam logic [STEP_W-1:0] STEP_RST = 16'd66;
	localparam logic [PAT_W-1:0]  PAT_RST  = 32'h2B2B_2B2B;
	localparam logic [FB_W-1:0]   FB_RST   = 8'd72;
	localparam logic [DL_W-1:0]   DL_RST   = 7'd10;

	localparam logic signed [WBITS-1:0] WEIGHT_ONE = 24'sh20_0000;

	localparam logic [4:0] PERIOD_NOM   = 5'd20;
	localparam logic [4:0] PERIOD_SHORT = 5'd19;
	localparam logic [4:0] PERIOD_LONG  = 5'd21;

	localparam logic [1:0] SIGN_NONE  = 2'd0;
	localparam logic [1:0] SIGN_PLUS  = 2'd1;
	localparam logic [1:0] SIGN_MINUS = 2'd2;

	localparam logic [3:0] OP_WI_XI = 4'd0;
	localparam logic [3:0] OP_WQ_XQ = 4'd1;
	localparam logic [3:0] OP_WQ_XI = 4'd2;
	localparam logic [3:0] OP_WI_XQ = 4'd3;
	localparam logic [3:0] OP_EI_XI = 4'd4;
	localparam logic [3:0] OP_EQ_XQ = 4'd5;
	localparam logic [3:0] OP_EQ_XI = 4'd6;
	localparam logic [3:0] OP_EI_XQ = 4'd7;
	localparam logic [3:0] OP_GI_ST = 4'd8;
	localparam logic [3:0] OP_GQ_ST = 4'd9;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_VOTE,
		ST_MUL,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic              found;
		logic              bvalid;
		logic [BYTE_W-1:0] bval;
		logic [BYTE_W-1:0] bidx;
		logic              fend;
	} frm_res_t;

endpackage

// ===== hw/rtl/dscf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dscf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 20
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/dscf_mul.sv =====
// Shared signed multiplier with registered product for the Costas update.
// Uses dscf_pkg for operand widths.
module dscf_mul (
	input  logic                                 clk,
	input  logic signed [dscf_pkg::MUL_A_W-1:0]  a,
	input  logic signed [dscf_pkg::MUL_B_W-1:0]  b,
	output logic signed [dscf_pkg::MUL_P_W-1:0]  p
);

	logic signed [dscf_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= dscf_pkg::MUL_P_W'(a) * dscf_pkg::MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

// ===== hw/rtl/dscf_framer.sv =====
// Preamble search and LSB-first byte collector driven by decided bits.
// Uses dscf_pkg for the result struct and widths.
module dscf_framer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          bit_in,
	input  logic [dscf_pkg::PAT_W-1:0]    pattern,
	input  logic [dscf_pkg::FB_W-1:0]     frame_bytes,
	output dscf_pkg::frm_res_t            res
);

	logic [dscf_pkg::PAT_W-1:0]  pre_q;
	logic                        in_frame_q;
	logic [dscf_pkg::BYTE_W-1:0] byte_q;
	logic [2:0]                  bit_cnt_q;
	logic [dscf_pkg::FB_W-1:0]   byte_cnt_q;

	logic [dscf_pkg::PAT_W-1:0]  pre_nxt;
	logic [dscf_pkg::BYTE_W-1:0] byte_nxt;
	logic [2:0]                  bit_cnt_nxt;
	logic [dscf_pkg::FB_W-1:0]   byte_cnt_inc;
	logic                        match;
	logic                        bdone;
	logic                        last;

	always_comb begin
		pre_nxt      = {bit_in, pre_q[dscf_pkg::PAT_W-1:1]};
		byte_nxt     = {bit_in, byte_q[dscf_pkg::BYTE_W-1:1]};
		bit_cnt_nxt  = bit_cnt_q + 3'd1;
		byte_cnt_inc = byte_cnt_q + 8'd1;
		match        = (pre_nxt == pattern);
		bdone        = (bit_cnt_nxt == 3'd0);
		last         = (byte_cnt_inc >= frame_bytes) || (byte_cnt_inc == 8'd0);

		res.found  = en && !in_frame_q && match;
		res.bvalid = en && in_frame_q && bdone;
		res.bval   = res.bvalid ? byte_nxt : '0;
		res.bidx   = res.bvalid ? byte_cnt_q : '0;
		res.fend   = res.bvalid && last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q      <= '0;
			in_frame_q <= 1'b0;
			byte_q     <= '0;
			bit_cnt_q  <= '0;
			byte_cnt_q <= '0;
		end else if (en) begin
			if (!in_frame_q) begin
				pre_q      <= match ? '0 : pre_nxt;
				in_frame_q <= match;
			end else begin
				byte_q    <= bdone ? '0 : byte_nxt;
				bit_cnt_q <= bit_cnt_nxt;
				if (bdone) begin
					byte_cnt_q <= last ? '0 : byte_cnt_inc;
					if (last) begin
						in_frame_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/dpsk_sync_costas_framer.sv =====
// Top level: DBPSK early-late symbol timing, LMS Costas rotation and frame capture.
// Uses dscf_pkg, dscf_ram, dscf_mul, dscf_framer and dpsk_sync_costas_framer_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, sample_i/sample_q) takes one matched-filter
//   I/Q pair per transaction. Output channel (out_valid/out_stall) returns exactly
//   one result transaction per input transaction, in order.
//   Configuration (cfg_we/cfg_index/cfg_data) is to be written while the block is idle;
//   the block does not enforce it. The sample window is a WINDOW_LEN-entry ring RAM.
// Sequence:
//   A sample that does not close a symbol goes from accept straight to the emit state.
//   A closing sample sweeps the window RAM for the early/late energies
//   (one RAM read a cycle), then passes a vote state, then uses the shared multiplier
//   for rotation and weight update, then emits. One transaction is in work at a time;
//   in_stall is high from accept until the result is loaded into the output register.
// Reset: control state clears at once; a fill count makes unwritten window entries read 0.
// Stall: a held result keeps its payload; the next input can be taken and worked on, and
//   its result waits until the output register frees.
module dpsk_sync_costas_framer #(
	parameter int WINDOW_LEN  = dscf_pkg::WINDOW_LEN_DEF,
	parameter int SAMPLE_BITS = dscf_pkg::SAMPLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dscf_pkg::CIDX_W-1:0]     cfg_index,
	input  logic [dscf_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [SAMPLE_BITS-1:0]   sample_i,
	input  logic signed [SAMPLE_BITS-1:0]   sample_q,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [SAMPLE_BITS-1:0]   rot_i,
	output logic signed [SAMPLE_BITS-1:0]   rot_q,
	output logic                            symbol_strobe,
	output logic                            bit_value,
	output logic                            frame_found,
	output logic                            byte_valid,
	output logic [dscf_pkg::BYTE_W-1:0]     byte_value,
	output logic [dscf_pkg::BYTE_W-1:0]     byte_index,
	output logic                            frame_end
);

	`include "dpsk_sync_costas_framer_defines.svh"

	localparam int SB   = SAMPLE_BITS;
	localparam int AW   = $clog2(WINDOW_LEN);
	localparam int FW   = $clog2(WINDOW_LEN + 1);
	localparam int CW   = $clog2(WINDOW_LEN + 2);
	localparam int HALF = WINDOW_LEN / 2;
	localparam int FRAC = SB - 2;
	localparam int EW   = 2 * SB + AW;
	localparam int YW   = SB + 25;
	localparam int DW   = YW + 2;
	localparam int TW   = SB + 29;
	localparam int EIW  = 28;
	localparam int GW   = 32;
	localparam int IW   = 34;
	localparam int SW   = IW + 1;
	localparam int WB   = dscf_pkg::WBITS;

	localparam logic [FW-1:0] FILL_MAX = FW'(WINDOW_LEN);
	localparam logic [AW-1:0] ADDR_MAX = AW'(WINDOW_LEN - 1);
	localparam logic [CW-1:0] CNT_LEN  = CW'(WINDOW_LEN);
	localparam logic [CW-1:0] CNT_END  = CW'(WINDOW_LEN + 1);
	localparam logic [CW-1:0] K_MID_A  = CW'(HALF - 1);
	localparam logic [CW-1:0] K_MID_B  = CW'(HALF);

	localparam logic signed [DW-1:0] D_ONE   = DW'(1) << (dscf_pkg::WFRAC + FRAC);
	localparam logic signed [DW-1:0] E_HALF  = DW'(1) << (FRAC - 1);
	localparam logic signed [TW-1:0] G_HALF  = TW'(1) << (FRAC - 1);
	localparam logic signed [YW-1:0] R_HALF  = YW'(1) << (dscf_pkg::WFRAC - 1);
	localparam logic signed [YW-1:0] R_MAX   = YW'((1 << (SB - 1)) - 1);
	localparam logic signed [YW-1:0] R_MIN   = -R_MAX - YW'(1);
	localparam logic signed [dscf_pkg::MUL_P_W-1:0] S_HALF = dscf_pkg::MUL_P_W'(1) << 15;
	localparam logic signed [SW-1:0] W_MAX   = SW'((1 << (WB - 1)) - 1);
	localparam logic signed [SW-1:0] W_MIN   = -W_MAX - SW'(1);

	function automatic logic signed [WB-1:0] sat_w(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] c;
		c = (v > W_MAX) ? W_MAX : ((v < W_MIN) ? W_MIN : v);
		return c[WB-1:0];
	endfunction

	function automatic logic signed [SB-1:0] sat_r(input logic signed [YW-1:0] y);
		logic signed [YW-1:0] r;
		logic signed [YW-1:0] c;
		r = (y + R_HALF) >>> dscf_pkg::WFRAC;
		c = (r > R_MAX) ? R_MAX : ((r < R_MIN) ? R_MIN : r);
		return c[SB-1:0];
	endfunction

	// configuration
	logic [dscf_pkg::STEP_W-1:0] step_q;
	logic [dscf_pkg::PAT_W-1:0]  pattern_q;
	logic [dscf_pkg::FB_W-1:0]   fbytes_q;
	logic [dscf_pkg::DL_W-1:0]   dlimit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= dscf_pkg::STEP_RST;
			pattern_q <= dscf_pkg::PAT_RST;
			fbytes_q  <= dscf_pkg::FB_RST;
			dlimit_q  <= dscf_pkg::DL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dscf_pkg::REG_STEP:    step_q    <= cfg_data[dscf_pkg::STEP_W-1:0];
				dscf_pkg::REG_PATTERN: pattern_q <= cfg_data[dscf_pkg::PAT_W-1:0];
				dscf_pkg::REG_FBYTES:  fbytes_q  <= cfg_data[dscf_pkg::FB_W-1:0];
				dscf_pkg::REG_DLIMIT:  dlimit_q  <= cfg_data[dscf_pkg::DL_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	dscf_pkg::state_t state_q, state_nxt;
	logic [4:0]    phase_q, period_q, phase_inc;
	logic [7:0]    votes_q;
	logic [AW-1:0] wp_q, wp_nxt, rd_addr_q;
	logic [FW-1:0] fill_q;
	logic [CW-1:0] cnt_q;
	logic          strobe_q;
	logic          strobe_hit;
	logic [3:0]    m_q, mop_q;
	logic          mv_q;
	logic [1:0]    last_sign_q;
	logic          out_valid_q;

	logic in_acc, issue, mul_issue, commit, sweep_done, mul_done;

	// sweep pipeline
	logic                    v_s1, ev_s1, v_s2, late_s2;
	logic [CW-1:0]           k_s1;
	logic signed [2*SB-1:0]  sqi_s2, sqq_s2;
	logic [EW-1:0]           ee_q, el_q;
	logic signed [SB-1:0]    di, dq;
	logic signed [SB-1:0]    ma_i_q, ma_q_q, mb_i_q, mb_q_q;
	logic signed [SB-1:0]    x_i_q, x_q_q;
	logic signed [SB:0]      xs_i, xs_q;
	logic [2*SB-1:0]         rdata;
	logic                    ent_vld;

	// Costas datapath
	logic signed [WB-1:0]    wi_q, wq_q;
	logic signed [TW-1:0]    t_q, pt, gs;
	logic signed [YW-1:0]    yi_q, yq_q;
	logic signed [GW-1:0]    gi_q, gq_q;
	logic signed [DW-1:0]    ediff, eqf;
	logic signed [EIW-1:0]   ei, eq;
	logic signed [TW-1:0]    gr;
	logic signed [dscf_pkg::MUL_P_W-1:0] p, pinc;
	logic signed [IW-1:0]    winc;
	logic signed [dscf_pkg::MUL_A_W-1:0] mul_a;
	logic signed [dscf_pkg::MUL_B_W-1:0] mul_b;
	logic                    sign_plus;
	logic [1:0]              sign_code;
	logic                    bit_d;

	// output
	logic signed [SB-1:0]        held_i_q, held_q_q, rot_i_q, rot_q_q, rn_i, rn_q;
	logic                        strobe_o_q, bit_o_q;
	dscf_pkg::frm_res_t          fres, fres_q;
	logic [7:0]                  votes_t, neg_lim;

	assign in_acc     = in_valid && !in_stall;
	assign phase_inc  = phase_q + 5'd1;
	assign strobe_hit = (phase_inc == period_q);
	assign wp_nxt     = (wp_q == ADDR_MAX) ? '0 : wp_q + AW'(1);
	assign ent_vld    = (fill_q == FILL_MAX) || (FW'(rd_addr_q) < fill_q);
	assign sweep_done = (cnt_q == CNT_END);
	assign mul_done   = mv_q && (mop_q == dscf_pkg::OP_GQ_ST);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dscf_pkg::ST_IDLE:  if (in_acc) state_nxt = strobe_hit ? dscf_pkg::ST_SWEEP
			                                                      : dscf_pkg::ST_EMIT;
			dscf_pkg::ST_SWEEP: if (sweep_done) state_nxt = dscf_pkg::ST_VOTE;
			dscf_pkg::ST_VOTE:  state_nxt = dscf_pkg::ST_MUL;
			dscf_pkg::ST_MUL:   if (mul_done) state_nxt = dscf_pkg::ST_EMIT;
			dscf_pkg::ST_EMIT:  if (!out_valid_q || !out_stall) state_nxt = dscf_pkg::ST_IDLE;
			default:            state_nxt = dscf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall  = 1'b1;
		issue     = 1'b0;
		mul_issue = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			dscf_pkg::ST_IDLE:  in_stall  = 1'b0;
			dscf_pkg::ST_SWEEP: issue     = (cnt_q < CNT_LEN);
			dscf_pkg::ST_VOTE:  ;
			dscf_pkg::ST_MUL:   mul_issue = (m_q <= dscf_pkg::OP_GQ_ST);
			dscf_pkg::ST_EMIT:  commit    = !out_valid_q || !out_stall;
			default: ;
		endcase
	end

	dscf_ram #(
		.WIDTH(2 * SB),
		.DEPTH(WINDOW_LEN)
	) u_win (
		.clk  (clk),
		.we   (in_acc),
		.waddr(wp_q),
		.wdata({sample_q, sample_i}),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	assign di = ev_s1 ? rdata[SB-1:0] : '0;
	assign dq = ev_s1 ? rdata[2*SB-1:SB] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dscf_pkg::ST_IDLE;
			phase_q <= 5'd1;
			period_q <= dscf_pkg::PERIOD_NOM;
			votes_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			rd_addr_q <= '0;
			cnt_q <= '0;
			strobe_q <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			m_q <= '0;
			mop_q <= '0;
			mv_q <= 1'b0;
			wi_q <= dscf_pkg::WEIGHT_ONE;
			wq_q <= '0;
			last_sign_q <= dscf_pkg::SIGN_NONE;
			held_i_q <= '0;
			held_q_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_acc) begin
				phase_q   <= strobe_hit ? 5'd0 : phase_inc;
				strobe_q  <= strobe_hit;
				wp_q      <= wp_nxt;
				rd_addr_q <= wp_nxt;
				fill_q    <= (fill_q == FILL_MAX) ? fill_q : fill_q + FW'(1);
				cnt_q     <= '0;
			end
			if (state_q == dscf_pkg::ST_SWEEP) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (issue) begin
				rd_addr_q <= (rd_addr_q == ADDR_MAX) ? '0 : rd_addr_q + AW'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (state_q == dscf_pkg::ST_VOTE) begin
				if (votes_t == {1'b0, dlimit_q}) begin
					votes_q  <= '0;
					period_q <= dscf_pkg::PERIOD_SHORT;
				end else if (votes_t == neg_lim) begin
					votes_q  <= '0;
					period_q <= dscf_pkg::PERIOD_LONG;
				end else begin
					votes_q  <= votes_t;
					period_q <= dscf_pkg::PERIOD_NOM;
				end
				m_q <= '0;
			end
			if (mul_issue) begin
				m_q <= m_q + 4'd1;
			end
			mv_q  <= mul_issue;
			mop_q <= m_q;
			if (mv_q && mop_q == dscf_pkg::OP_GI_ST) begin
				wi_q <= sat_w(SW'(wi_q) + SW'(winc));
			end
			if (mv_q && mop_q == dscf_pkg::OP_GQ_ST) begin
				wq_q <= sat_w(SW'(wq_q) + SW'(winc));
			end
			if (commit && strobe_q) begin
				last_sign_q <= sign_code;
				held_i_q    <= rn_i;
				held_q_q    <= rn_q;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// sweep datapath and Costas registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ee_q <= '0;
			el_q <= '0;
		end
		if (issue) begin
			k_s1  <= cnt_q;
			ev_s1 <= ent_vld;
		end
		if (v_s1) begin
			sqi_s2  <= (2 * SB)'(di) * (2 * SB)'(di);
			sqq_s2  <= (2 * SB)'(dq) * (2 * SB)'(dq);
			late_s2 <= (k_s1 >= K_MID_B);
			if (k_s1 == K_MID_A) begin
				ma_i_q <= di;
				ma_q_q <= dq;
			end
			if (k_s1 == K_MID_B) begin
				mb_i_q <= di;
				mb_q_q <= dq;
			end
		end
		if (v_s2) begin
			if (late_s2) begin
				el_q <= el_q + EW'($unsigned(sqi_s2)) + EW'($unsigned(sqq_s2));
			end else begin
				ee_q <= ee_q + EW'($unsigned(sqi_s2)) + EW'($unsigned(sqq_s2));
			end
		end
		if (state_q == dscf_pkg::ST_VOTE) begin
			x_i_q <= xs_i[SB:1];
			x_q_q <= xs_q[SB:1];
		end
		if (mv_q) begin
			case (mop_q)
				dscf_pkg::OP_WI_XI: t_q  <= pt;
				dscf_pkg::OP_WQ_XQ: yi_q <= YW'(t_q - pt);
				dscf_pkg::OP_WQ_XI: t_q  <= pt;
				dscf_pkg::OP_WI_XQ: yq_q <= YW'(t_q + pt);
				dscf_pkg::OP_EI_XI: t_q  <= pt;
				dscf_pkg::OP_EQ_XQ: gi_q <= gr[GW-1:0];
				dscf_pkg::OP_EQ_XI: t_q  <= pt;
				dscf_pkg::OP_EI_XQ: gq_q <= gr[GW-1:0];
				default: ;
			endcase
		end
		if (commit) begin
			strobe_o_q <= strobe_q;
			bit_o_q    <= bit_d;
			rot_i_q    <= strobe_q ? rn_i : held_i_q;
			rot_q_q    <= strobe_q ? rn_q : held_q_q;
			fres_q     <= fres;
		end
	end

	always_comb begin
		xs_i    = {ma_i_q[SB-1], ma_i_q} + {mb_i_q[SB-1], mb_i_q};
		xs_q    = {ma_q_q[SB-1], ma_q_q} + {mb_q_q[SB-1], mb_q_q};
		neg_lim = 8'd0 - {1'b0, dlimit_q};
		if (ee_q > el_q) begin
			votes_t = votes_q + 8'd1;
		end else if (ee_q < el_q) begin
			votes_t = votes_q - 8'd1;
		end else begin
			votes_t = votes_q;
		end

		sign_plus = (yi_q > YW'(0));
		sign_code = sign_plus ? dscf_pkg::SIGN_PLUS : dscf_pkg::SIGN_MINUS;
		bit_d     = strobe_q && (sign_code != last_sign_q);
		ediff     = (sign_plus ? D_ONE : -D_ONE) - DW'(yi_q) + E_HALF;
		ei        = EIW'(ediff >>> FRAC);
		eqf       = E_HALF - DW'(yq_q);
		eq        = EIW'(eqf >>> FRAC);

		pt   = TW'(p);
		gs   = (mop_q == dscf_pkg::OP_EQ_XQ) ? t_q + pt : t_q - pt;
		gr   = (gs + G_HALF) >>> FRAC;
		pinc = (p + S_HALF) >>> 16;
		winc = IW'(pinc);

		rn_i = sat_r(yi_q);
		rn_q = sat_r(yq_q);
	end

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (m_q)
			dscf_pkg::OP_WI_XI: begin
				mul_a = dscf_pkg::MUL_A_W'(wi_q);
				mul_b = dscf_pkg::MUL_B_W'(x_i_q);
			end
			dscf_pkg::OP_WQ_XQ: begin
				mul_a = dscf_pkg::MUL_A_W'(wq_q);
				mul_b = dscf_pkg::MUL_B_W'(x_q_q);
			end
			dscf_pkg::OP_WQ_XI: begin
				mul_a = dscf_pkg::MUL_A_W'(wq_q);
				mul_b = dscf_pkg::MUL_B_W'(x_i_q);
			end
			dscf_pkg::OP_WI_XQ: begin
				mul_a = dscf_pkg::MUL_A_W'(wi_q);
				mul_b = dscf_pkg::MUL_B_W'(x_q_q);
			end
			dscf_pkg::OP_EI_XI: begin
				mul_a = dscf_pkg::MUL_A_W'(ei);
				mul_b = dscf_pkg::MUL_B_W'(x_i_q);
			end
			dscf_pkg::OP_EQ_XQ: begin
				mul_a = dscf_pkg::MUL_A_W'(eq);
				mul_b = dscf_pkg::MUL_B_W'(x_q_q);
			end
			dscf_pkg::OP_EQ_XI: begin
				mul_a = dscf_pkg::MUL_A_W'(eq);
				mul_b = dscf_pkg::MUL_B_W'(x_i_q);
			end
			dscf_pkg::OP_EI_XQ: begin
				mul_a = dscf_pkg::MUL_A_W'(ei);
				mul_b = dscf_pkg::MUL_B_W'(x_q_q);
			end
			dscf_pkg::OP_GI_ST: begin
				mul_a = dscf_pkg::MUL_A_W'(gi_q);
				mul_b = dscf_pkg::MUL_B_W'($signed({1'b0, step_q}));
			end
			dscf_pkg::OP_GQ_ST: begin
				mul_a = dscf_pkg::MUL_A_W'(gq_q);
				mul_b = dscf_pkg::MUL_B_W'($signed({1'b0, step_q}));
			end
			default: ;
		endcase
	end

	dscf_mul u_mul (
		.clk(clk),
		.a  (mul_a),
		.b  (mul_b),
		.p  (p)
	);

	dscf_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (commit && strobe_q),
		.bit_in     (bit_d),
		.pattern    (pattern_q),
		.frame_bytes(fbytes_q),
		.res        (fres)
	);

	assign out_valid     = out_valid_q;
	assign rot_i         = rot_i_q;
	assign rot_q         = rot_q_q;
	assign symbol_strobe = strobe_o_q;
	assign bit_value     = bit_o_q;
	assign frame_found   = fres_q.found;
	assign byte_valid    = fres_q.bvalid;
	assign byte_value    = fres_q.bval;
	assign byte_index    = fres_q.bidx;
	assign frame_end     = fres_q.fend;

	`DSCF_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= FILL_MAX, "window fill count overran")
	`DSCF_ASSERT_IMP(a_raddr_bound, issue, rd_addr_q <= ADDR_MAX,
		"window read address out of range")
	`DSCF_ASSERT_NXT(a_plain_emit, in_acc && !strobe_hit, state_q == dscf_pkg::ST_EMIT,
		"non-closing sample did not go straight to emit")
	`DSCF_ASSERT_IMP(a_byte_strobe, out_valid && byte_valid, symbol_strobe,
		"byte completed without a symbol strobe")

endmodule

// ===== verif/dpsk_sync_costas_framer_test.sv =====
// Self-checking testbench for dpsk_sync_costas_framer: symbol timing, Costas rotation, framing.
// Drives I/Q samples over valid/stall and checks each result against a built-in predictor.
// Depends on dscf_pkg and the dpsk_sync_costas_framer RTL only.
module dpsk_sync_costas_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] ri;
		logic signed [15:0] rq;
		logic               strobe;
		logic               bitv;
		logic               found;
		logic               bvalid;
		logic [7:0]         bval;
		logic [7:0]         bidx;
		logic               fend;
	} sym_res_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [dscf_pkg::CIDX_W-1:0] cfg_index = dscf_pkg::REG_STEP;
	logic [dscf_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0, out_stall = 0;
	logic signed [15:0] sample_i = '0, sample_q = '0;
	logic in_stall, out_valid, symbol_strobe, bit_value, frame_found, byte_valid, frame_end;
	logic signed [15:0] rot_i, rot_q;
	logic [7:0] byte_value, byte_index;

	dpsk_sync_costas_framer dut (.*);

	always #2 clk = ~clk;

	// predictor state and config
	longint win_i[20], win_q[20];
	int sym_phase, sym_len;
	logic [7:0] votes;
	longint w_i, w_q, hold_i, hold_q;
	logic [1:0] prev_sign;
	bit in_frame;
	logic [31:0] pre_sr;
	logic [7:0] byte_sr, byte_cnt;
	int bit_cnt;
	logic [15:0] cfg_step;
	logic [31:0] cfg_pat;
	logic [7:0] cfg_fb;
	logic [6:0] cfg_dl;

	logic [31:0] pending_samples[$];
	sym_res_t expected_syms[$];
	int errors = 0, checked = 0, cycles = 0;
	int send_gap = 0, recv_gap = 0, hold_left = 0;
	bit quiet = 0, held_once = 0, acc_last = 0;

	function automatic longint rnd(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, int bits);
		longint hi;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
	endfunction

	function automatic sym_res_t track_symbol(logic signed [15:0] si, logic signed [15:0] sq);
		longint e_early, e_late, xi, xq, yi, yq, d, ei, eq, gi, gq, vs;
		logic [1:0] sgn;
		sym_res_t r;
		r = '0;
		for (int k = 0; k < 19; k++) begin
			win_i[k] = win_i[k+1];
			win_q[k] = win_q[k+1];
		end
		win_i[19] = longint'(si);
		win_q[19] = longint'(sq);
		sym_phase = (sym_phase + 1) & 31;
		if (sym_phase == sym_len) begin
			r.strobe = 1'b1;
			e_early = 0;
			e_late = 0;
			for (int k = 0; k < 10; k++) begin
				e_early += win_i[k] * win_i[k] + win_q[k] * win_q[k];
				e_late += win_i[k+10] * win_i[k+10] + win_q[k+10] * win_q[k+10];
			end
			if (e_early > e_late) votes = votes + 8'd1;
			else if (e_early < e_late) votes = votes - 8'd1;
			vs = longint'($signed(votes));
			if (vs == longint'(cfg_dl)) begin
				votes = '0;
				sym_len = int'(dscf_pkg::PERIOD_SHORT);
			end else if (vs == -longint'(cfg_dl)) begin
				votes = '0;
				sym_len = int'(dscf_pkg::PERIOD_LONG);
			end else begin
				sym_len = int'(dscf_pkg::PERIOD_NOM);
			end
			sym_phase = 0;
			xi = (win_i[9] + win_i[10]) >>> 1;
			xq = (win_q[9] + win_q[10]) >>> 1;
			yi = w_i * xi - w_q * xq;
			yq = w_q * xi + w_i * xq;
			hold_i = clip(rnd(yi, dscf_pkg::WFRAC), 16);
			hold_q = clip(rnd(yq, dscf_pkg::WFRAC), 16);
			sgn = (yi > 0) ? dscf_pkg::SIGN_PLUS : dscf_pkg::SIGN_MINUS;
			d = longint'(1) <<< (dscf_pkg::WFRAC + 14);
			if (sgn == dscf_pkg::SIGN_MINUS) d = -d;
			ei = rnd(d - yi, 14);
			eq = rnd(-yq, 14);
			gi = rnd(ei * xi + eq * xq, 14);
			gq = rnd(eq * xi - ei * xq, 14);
			w_i = clip(w_i + rnd(longint'(cfg_step) * gi, 16), dscf_pkg::WBITS);
			w_q = clip(w_q + rnd(longint'(cfg_step) * gq, 16), dscf_pkg::WBITS);
			r.bitv = (sgn != prev_sign);
			prev_sign = sgn;
			if (!in_frame) begin
				pre_sr = {r.bitv, pre_sr[31:1]};
				if (pre_sr == cfg_pat) begin
					in_frame = 1'b1;
					pre_sr = '0;
					r.found = 1'b1;
				end
			end else begin
				byte_sr = {r.bitv, byte_sr[7:1]};
				bit_cnt = (bit_cnt + 1) & 7;
				if (bit_cnt == 0) begin
					r.bvalid = 1'b1;
					r.bval = byte_sr;
					r.bidx = byte_cnt;
					byte_cnt = byte_cnt + 8'd1;
					byte_sr = '0;
					if (byte_cnt >= cfg_fb || byte_cnt == 8'd0) begin
						byte_cnt = '0;
						in_frame = 1'b0;
						r.fend = 1'b1;
					end
				end
			end
		end
		r.ri = hold_i[15:0];
		r.rq = hold_q[15:0];
		return r;
	endfunction

	// acceptance, prediction and checking
	always @(posedge clk) begin
		sym_res_t e, a;
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("FAILURE");
			$finish;
		end
		acc_last <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			expected_syms.push_back(track_symbol(sample_i, sample_q));
		if (out_valid && !out_stall) begin
			a = '{rot_i, rot_q, symbol_strobe, bit_value, frame_found, byte_valid,
				byte_value, byte_index, frame_end};
			checked <= checked + 1;
			if (expected_syms.size() == 0) begin
				errors++;
				$display("%0t unexpected transaction: %p", $time, a);
			end else begin
				e = expected_syms.pop_front();
				if (a !== e) begin
					errors++;
					$display("%0t mismatch: expected %p actual %p", $time, e, a);
				end
			end
		end
	end

	// sample driver
	always @(negedge clk) begin
		if (!(in_valid && !acc_last)) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 0;
			end else if (pending_samples.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
				send_gap <= $urandom_range(0, 11);
				in_valid <= 0;
			end else if (pending_samples.size() > 0) begin
				{sample_i, sample_q} <= pending_samples.pop_front();
				in_valid <= 1;
			end else begin
				in_valid <= 0;
			end
		end
	end

	// result-side stall
	always @(negedge clk) begin
		if (checked >= 200 && !held_once) begin
			held_once <= 1;
			hold_left <= 300;
			out_stall <= 1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_stall <= 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			recv_gap <= $urandom_range(0, 11);
			out_stall <= 1;
		end else begin
			out_stall <= 0;
		end
	end

	task automatic drain();
		while (pending_samples.size() > 0 || in_valid || expected_syms.size() > 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [dscf_pkg::CIDX_W-1:0] idx, logic [31:0] val);
		case (idx)
			dscf_pkg::REG_STEP:    cfg_step = val[15:0];
			dscf_pkg::REG_PATTERN: cfg_pat = val;
			dscf_pkg::REG_FBYTES:  cfg_fb = val[7:0];
			dscf_pkg::REG_DLIMIT:  cfg_dl = val[6:0];
			default:     ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_noise(int n);
		repeat (n) pending_samples.push_back($urandom());
	endtask

	// DBPSK waveform: a 1 bit flips the carrier sign, 20 samples a symbol
	task automatic push_bits(logic [63:0] bits, int nbits);
		int s, amp;
		logic signed [15:0] vi, vq;
		s = 1;
		amp = $urandom_range(6000, 14000);
		for (int b = 0; b < nbits; b++) begin
			if (bits[b]) s = -s;
			repeat (20) begin
				vi = 16'(s * amp + $signed($urandom_range(0, 1000)) - 500);
				vq = 16'($signed($urandom_range(0, 1000)) - 500);
				pending_samples.push_back({vi, vq});
			end
		end
	endtask

	initial begin
		logic [63:0] frame_bits;
		cfg_step = dscf_pkg::STEP_RST;
		cfg_pat = dscf_pkg::PAT_RST;
		cfg_fb = dscf_pkg::FB_RST;
		cfg_dl = dscf_pkg::DL_RST;
		foreach (win_i[k]) begin
			win_i[k] = 0;
			win_q[k] = 0;
		end
		sym_phase = 1;
		sym_len = int'(dscf_pkg::PERIOD_NOM);
		votes = '0;
		w_i = longint'(dscf_pkg::WEIGHT_ONE);
		w_q = 0;
		hold_i = 0;
		hold_q = 0;
		prev_sign = dscf_pkg::SIGN_NONE;
		in_frame = 1'b0;
		pre_sr = '0;
		byte_sr = '0;
		byte_cnt = '0;
		bit_cnt = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		for (int k = 0; k < 25; k++)
			case (k % 5)
				0: pending_samples.push_back({16'sh7FFF, 16'sh7FFF});
				1: pending_samples.push_back({16'sh8000, 16'sh8000});
				2: pending_samples.push_back({16'sh8000, 16'sh7FFF});
				3: pending_samples.push_back({16'sh7FFF, 16'sh8000});
				default: pending_samples.push_back(32'd0);
			endcase
		push_noise(60);
		drain();

		write_reg(dscf_pkg::REG_STEP, 32'h0000_FFFF);
		write_reg(dscf_pkg::REG_PATTERN, 32'd0);
		write_reg(dscf_pkg::REG_FBYTES, 32'd255);
		write_reg(dscf_pkg::REG_DLIMIT, 32'd1);
		push_noise(120);
		drain();

		write_reg(dscf_pkg::REG_STEP, $urandom_range(0, 4000));
		write_reg(dscf_pkg::REG_PATTERN, $urandom());
		write_reg(dscf_pkg::REG_FBYTES, 32'd1);
		write_reg(dscf_pkg::REG_DLIMIT, 32'd127);
		frame_bits = {17'd0, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), cfg_pat,
			4'($urandom())};
		push_bits(frame_bits, 47);
		wait (pending_samples.size() < 150);
		quiet = 1;
		drain();

		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

// ===== dpsk_sync_costas_framer.f =====
+incdir+hw/rtl
hw/rtl/dscf_pkg.sv
hw/rtl/dscf_ram.sv
hw/rtl/dscf_mul.sv
hw/rtl/dscf_framer.sv
hw/rtl/dpsk_sync_costas_framer.sv
verif/dpsk_sync_costas_framer_test.sv
